### hdl/pdd_pkg.sv
// Package: sizes, codes and shared types of the pin edge dispatch table
`default_nettype none
package pdd_pkg;

	// Table and port sizes
	localparam int SLOTS     = 16;
	localparam int NUM_PORTS = 8;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Operation codes
	typedef enum logic [1:0] {
		OP_REGISTER   = 2'd0,
		OP_UNREGISTER = 2'd1,
		OP_ENABLE     = 2'd2,
		OP_DISPATCH   = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		STS_OK         = 2'd0,
		STS_FULL       = 2'd1,
		STS_NO_HANDLER = 2'd2,
		STS_NOT_FOUND  = 2'd3
	} status_t;

	// Edge codes (also the edge mask bits)
	localparam logic [1:0] EDGE_NONE = 2'd0;
	localparam logic [1:0] EDGE_RISE = 2'd1;
	localparam logic [1:0] EDGE_FALL = 2'd2;

	// One table entry
	typedef struct packed {
		logic [2:0]  port;
		logic [15:0] pin;
		logic [15:0] handler;
		logic [31:0] tag;
		logic [1:0]  edges;
		logic [31:0] debounce;
		logic [31:0] fire_time;
		logic        level;
	} entry_t;

	// Table write command
	typedef struct packed {
		logic              fill;
		logic              clear;
		logic              set_en;
		logic              en_val;
		logic              set_level;
		logic              set_time;
		logic [SLOT_W-1:0] idx;
		entry_t            data;
	} wr_t;

	// Per-slot evaluation from the compare unit
	typedef struct packed {
		logic       match;
		logic       free;
		logic       touch;
		logic       fire;
		logic       upd_time;
		logic       new_level;
		logic [1:0] seen;
	} eval_t;

	// One result beat
	typedef struct packed {
		status_t     status;
		logic [3:0]  slot;
		logic        fired;
		logic [1:0]  edge_seen;
		logic [15:0] handler;
		logic [31:0] tag;
		logic [15:0] pin;
		logic        last;
	} res_t;

	// Slot number to the 4-bit result field
	function automatic logic [3:0] to_slot4(input logic [SLOT_W-1:0] s);
		logic [31:0] w;
		begin
			w = 32'(s);
			return w[3:0];
		end
	endfunction

endpackage
`default_nettype wire

### hdl/pdd_cmd_if.sv
// Interface: command channel carrying one operation beat
`default_nettype none
interface pdd_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [2:0]  port_index;
	logic [15:0] pin_mask;
	logic [15:0] handler_id;
	logic [31:0] user_tag;
	logic [1:0]  edge_select;
	logic [31:0] debounce_time;
	logic        current_level;
	logic        enable_flag;
	logic [7:0]  port_levels;
	logic [31:0] now_time;

	modport source (
		output valid, operation, port_index, pin_mask, handler_id, user_tag,
		       edge_select, debounce_time, current_level, enable_flag,
		       port_levels, now_time,
		input  ready
	);
	modport sink (
		input  valid, operation, port_index, pin_mask, handler_id, user_tag,
		       edge_select, debounce_time, current_level, enable_flag,
		       port_levels, now_time,
		output ready
	);
endinterface
`default_nettype wire

### hdl/pdd_res_if.sv
// Interface: result channel carrying one status or notification beat
`default_nettype none
interface pdd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  slot_index;
	logic        fired;
	logic [1:0]  edge_seen;
	logic [15:0] notify_handler;
	logic [31:0] notify_tag;
	logic [15:0] notify_pin;
	logic        last_result;

	modport source (
		output valid, status, slot_index, fired, edge_seen, notify_handler,
		       notify_tag, notify_pin, last_result,
		input  ready
	);
	modport sink (
		input  valid, status, slot_index, fired, edge_seen, notify_handler,
		       notify_tag, notify_pin, last_result,
		output ready
	);
endinterface
`default_nettype wire

### hdl/pdd_table.sv
// Slot table: used/enable flags with reset, entry payload without
`default_nettype none
module pdd_table
	import pdd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [SLOT_W-1:0] rd_idx,
	input  wire wr_t               wr,
	output entry_t                 rd_entry,
	output logic                   rd_used,
	output logic                   rd_en
);

	logic [SLOTS-1:0] used_q;
	logic [SLOTS-1:0] en_q;
	entry_t           ent_q [SLOTS];

	// Read port at the scan index
	assign rd_entry = ent_q[rd_idx];
	assign rd_used  = used_q[rd_idx];
	assign rd_en    = en_q[rd_idx];

	// Flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			en_q   <= '0;
		end else begin
			if (wr.fill) begin
				used_q[wr.idx] <= 1'b1;
				en_q[wr.idx]   <= 1'b1;
			end else if (wr.clear) begin
				used_q[wr.idx] <= 1'b0;
				en_q[wr.idx]   <= 1'b0;
			end else if (wr.set_en) begin
				en_q[wr.idx] <= wr.en_val;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (wr.fill) begin
			ent_q[wr.idx] <= wr.data;
		end else begin
			if (wr.set_level) begin
				ent_q[wr.idx].level <= wr.data.level;
			end
			if (wr.set_time) begin
				ent_q[wr.idx].fire_time <= wr.data.fire_time;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/pdd_eval.sv
// Shared compare unit: lookup match, free check, edge and debounce test of one slot
`default_nettype none
module pdd_eval
	import pdd_pkg::*;
(
	input  wire entry_t      ent,
	input  wire logic        used,
	input  wire logic        en,
	input  wire logic [2:0]  port,
	input  wire logic [15:0] pin,
	input  wire logic [7:0]  levels,
	input  wire logic [31:0] now,
	output eval_t            ev
);

	logic        cand;
	logic        nowlvl;
	logic [1:0]  seen;
	logic [31:0] elapsed;
	logic        deb_on;
	logic        locked;

	// Level of the slot's port and the edge it makes
	assign nowlvl  = levels[ent.port];
	assign seen    = nowlvl ? EDGE_RISE : EDGE_FALL;
	assign cand    = used && en && (ent.handler != 16'd0) && (ent.pin == pin);

	// Wrapping time since last fire against the lockout
	assign elapsed = now - ent.fire_time;
	assign deb_on  = ent.debounce != 32'd0;
	assign locked  = deb_on && (elapsed < ent.debounce);

	always_comb begin
		ev           = '0;
		ev.match     = used && (ent.port == port) && (ent.pin == pin);
		ev.free      = !used;
		ev.touch     = cand && (nowlvl != ent.level);
		ev.fire      = ev.touch && ((ent.edges & seen) != 2'd0) && !locked;
		ev.upd_time  = ev.fire && deb_on;
		ev.new_level = nowlvl;
		ev.seen      = seen;
	end

endmodule
`default_nettype wire

### hdl/pin_edge_debounce_dispatch_table_unit.sv
// Top level: sequencer walking the slot table through the shared compare unit
// Every operation scans all SLOTS entries, one per cycle unless a dispatch stall holds the scan,
// then passes through the finish state, which waits for the result register to be free before
// offering the final result and returning to idle; a new command is taken only in idle.
// A dispatch holds back one notification and hands it on when the next fire is found; the
// scan pauses while that one waits for the result register. Reset clears all used and
// enable flags and the sequencer.
`default_nettype none
module pin_edge_debounce_dispatch_table_unit
	import pdd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	pdd_cmd_if.sink   cmd,
	pdd_res_if.source res
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] idx_q;
	logic              hit_q, free_q;
	logic [SLOT_W-1:0] hit_idx_q, free_idx_q;
	logic              pend_valid_q;
	res_t              pend_q;
	logic              res_valid_q;
	res_t              res_q;

	// Captured command
	op_t         op_q;
	logic [2:0]  port_q;
	logic [15:0] pin_q;
	logic [15:0] handler_q;
	logic [31:0] tag_q;
	logic [1:0]  edges_q;
	logic [31:0] deb_q;
	logic        level_q;
	logic        en_flag_q;
	logic [7:0]  levels_q;
	logic [31:0] now_q;

	entry_t rd_entry;
	logic   rd_used, rd_en;
	eval_t  ev;
	wr_t    wr;
	res_t   fire_res, fin_res;
	logic   cmd_acc, out_free, is_disp, stall, advance, fin_go;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign out_free  = !res_valid_q || res.ready;
	assign is_disp   = (op_q == OP_DISPATCH);
	assign stall     = is_disp && ev.fire && pend_valid_q && !out_free;
	assign advance   = (state_q == ST_SCAN) && !stall;
	assign fin_go    = (state_q == ST_FIN) && out_free;

	pdd_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (idx_q),
		.wr       (wr),
		.rd_entry (rd_entry),
		.rd_used  (rd_used),
		.rd_en    (rd_en)
	);

	pdd_eval u_eval (
		.ent    (rd_entry),
		.used   (rd_used),
		.en     (rd_en),
		.port   (port_q),
		.pin    (pin_q),
		.levels (levels_q),
		.now    (now_q),
		.ev     (ev)
	);

	// Notification for the slot under scan
	always_comb begin
		fire_res           = '0;
		fire_res.status    = STS_OK;
		fire_res.slot      = to_slot4(idx_q);
		fire_res.fired     = 1'b1;
		fire_res.edge_seen = ev.seen;
		fire_res.handler   = rd_entry.handler;
		fire_res.tag       = rd_entry.tag;
		fire_res.pin       = pin_q;
		fire_res.last      = 1'b0;
	end

	// Table writes and the finishing result
	always_comb begin
		wr                = '0;
		wr.data.port      = port_q;
		wr.data.pin       = pin_q;
		wr.data.handler   = handler_q;
		wr.data.tag       = tag_q;
		wr.data.edges     = edges_q;
		wr.data.debounce  = deb_q;
		wr.data.fire_time = now_q;
		wr.data.level     = level_q;
		wr.idx            = idx_q;
		fin_res           = '0;
		fin_res.status    = STS_OK;
		fin_res.last      = 1'b1;
		if (state_q == ST_SCAN) begin
			wr.data.level = ev.new_level;
			wr.set_level  = is_disp && advance && ev.touch;
			wr.set_time   = is_disp && advance && ev.upd_time;
		end
		case (op_q)
			OP_REGISTER: begin
				wr.idx = hit_q ? hit_idx_q : free_idx_q;
				if ((handler_q == 16'd0) || (32'(port_q) >= 32'(NUM_PORTS))) begin
					fin_res.status = STS_NO_HANDLER;
				end else if (!hit_q && !free_q) begin
					fin_res.status = STS_FULL;
				end else begin
					fin_res.slot = to_slot4(wr.idx);
					wr.fill      = fin_go;
				end
			end
			OP_UNREGISTER, OP_ENABLE: begin
				if (state_q != ST_SCAN) begin
					wr.idx = hit_idx_q;
				end
				if (!hit_q) begin
					fin_res.status = STS_NOT_FOUND;
				end else begin
					fin_res.slot = to_slot4(hit_idx_q);
					wr.clear     = fin_go && (op_q == OP_UNREGISTER);
					wr.set_en    = fin_go && (op_q == OP_ENABLE);
					wr.en_val    = en_flag_q;
				end
			end
			OP_DISPATCH: begin
				if (pend_valid_q) begin
					fin_res      = pend_q;
					fin_res.last = 1'b1;
				end
			end
			default: begin
				fin_res.status = STS_OK;
			end
		endcase
		if (state_q == ST_FIN && op_q == OP_REGISTER) begin
			wr.idx = hit_q ? hit_idx_q : free_idx_q;
		end
	end

	// Command capture
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			op_q      <= op_t'(cmd.operation);
			port_q    <= cmd.port_index;
			pin_q     <= cmd.pin_mask;
			handler_q <= cmd.handler_id;
			tag_q     <= cmd.user_tag;
			edges_q   <= cmd.edge_select;
			deb_q     <= cmd.debounce_time;
			level_q   <= cmd.current_level;
			en_flag_q <= cmd.enable_flag;
			levels_q  <= cmd.port_levels;
			now_q     <= cmd.now_time;
		end
	end

	// Sequencer, lookup tracking and result staging
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			hit_idx_q    <= '0;
			free_idx_q   <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						state_q      <= ST_SCAN;
						idx_q        <= '0;
						hit_q        <= 1'b0;
						free_q       <= 1'b0;
						pend_valid_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (advance) begin
						// first matching and first free slot
						if (ev.match && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= idx_q;
						end
						if (ev.free && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_q;
						end
						// notifications: hand the held one on, hold the new one
						if (is_disp && ev.fire) begin
							pend_valid_q <= 1'b1;
							if (pend_valid_q) begin
								res_valid_q <= 1'b1;
							end
						end
						if (idx_q == SLOT_W'(SLOTS - 1)) begin
							state_q <= ST_FIN;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						res_valid_q  <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result and held-notification payload
	always_ff @(posedge clk) begin
		if (advance && is_disp && ev.fire) begin
			pend_q <= fire_res;
			if (pend_valid_q) begin
				res_q <= pend_q;
			end
		end
		if (fin_go) begin
			res_q <= fin_res;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.status         = res_q.status;
	assign res.slot_index     = res_q.slot;
	assign res.fired          = res_q.fired;
	assign res.edge_seen      = res_q.edge_seen;
	assign res.notify_handler = res_q.handler;
	assign res.notify_tag     = res_q.tag;
	assign res.notify_pin     = res_q.pin;
	assign res.last_result    = res_q.last;

endmodule
`default_nettype wire

### test/pdd_dispatch_checker.sv
// Checker: predicts the slot table's response to each command beat and compares result beats
`timescale 1ns / 1ps
module pdd_dispatch_checker
	import pdd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	pdd_cmd_if        cmd,
	pdd_res_if        res,
	output int        mismatch_count,
	output int        beats_owed
);

	localparam int PRINT_CAP = 150;

	// Own copy of the registration table
	logic   slot_used [SLOTS];
	logic   slot_on   [SLOTS];
	entry_t slot_tab  [SLOTS];

	// Result beats still owed by the block, oldest first
	res_t expected_beats [$];
	int   lines_printed;

	function automatic res_t status_beat(input status_t s, input int slot);
		res_t b;
		b = '0;
		b.status = s;
		b.slot   = 4'(slot);
		b.last   = 1'b1;
		return b;
	endfunction

	function automatic int find_slot(input logic [2:0] port, input logic [15:0] pin);
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_used[i] && slot_tab[i].port == port && slot_tab[i].pin == pin)
				return i;
		end
		return -1;
	endfunction

	function automatic int free_slot();
		for (int i = 0; i < SLOTS; i++) begin
			if (!slot_used[i])
				return i;
		end
		return -1;
	endfunction

	// Work out the beats caused by the command beat now on the channel
	task automatic predict_command();
		op_t         op;
		int          hit;
		int          fired_cnt;
		logic        lvl;
		logic [1:0]  seen;
		logic [31:0] elapsed;
		res_t        b;
		op = op_t'(cmd.operation);
		case (op)
			OP_REGISTER: begin
				if (cmd.handler_id == '0 || int'(cmd.port_index) >= NUM_PORTS) begin
					expected_beats.push_back(status_beat(STS_NO_HANDLER, 0));
				end else begin
					hit = find_slot(cmd.port_index, cmd.pin_mask);
					if (hit < 0)
						hit = free_slot();
					if (hit < 0) begin
						expected_beats.push_back(status_beat(STS_FULL, 0));
					end else begin
						slot_used[hit]           = 1'b1;
						slot_on[hit]             = 1'b1;
						slot_tab[hit].port       = cmd.port_index;
						slot_tab[hit].pin        = cmd.pin_mask;
						slot_tab[hit].handler    = cmd.handler_id;
						slot_tab[hit].tag        = cmd.user_tag;
						slot_tab[hit].edges      = cmd.edge_select;
						slot_tab[hit].debounce   = cmd.debounce_time;
						slot_tab[hit].fire_time  = cmd.now_time;
						slot_tab[hit].level      = cmd.current_level;
						expected_beats.push_back(status_beat(STS_OK, hit));
					end
				end
			end
			OP_UNREGISTER, OP_ENABLE: begin
				hit = find_slot(cmd.port_index, cmd.pin_mask);
				if (hit < 0) begin
					expected_beats.push_back(status_beat(STS_NOT_FOUND, 0));
				end else begin
					if (op == OP_UNREGISTER) begin
						slot_used[hit]        = 1'b0;
						slot_on[hit]          = 1'b0;
						slot_tab[hit].handler = '0;
						slot_tab[hit].tag     = '0;
					end else begin
						slot_on[hit] = cmd.enable_flag;
					end
					expected_beats.push_back(status_beat(STS_OK, hit));
				end
			end
			default: begin
				// dispatch: walk slots in order, one notification per fire
				fired_cnt = 0;
				for (int i = 0; i < SLOTS; i++) begin
					if (!slot_used[i] || !slot_on[i] || slot_tab[i].handler == '0)
						continue;
					if (slot_tab[i].pin != cmd.pin_mask)
						continue;
					lvl = cmd.port_levels[slot_tab[i].port];
					if (lvl == slot_tab[i].level)
						continue;
					seen = lvl ? EDGE_RISE : EDGE_FALL;
					slot_tab[i].level = lvl;
					if ((slot_tab[i].edges & seen) == '0)
						continue;
					// lockout on wrapping elapsed time
					if (slot_tab[i].debounce != '0) begin
						elapsed = cmd.now_time - slot_tab[i].fire_time;
						if (elapsed < slot_tab[i].debounce)
							continue;
						slot_tab[i].fire_time = cmd.now_time;
					end
					b           = '0;
					b.status    = STS_OK;
					b.slot      = 4'(i);
					b.fired     = 1'b1;
					b.edge_seen = seen;
					b.handler   = slot_tab[i].handler;
					b.tag       = slot_tab[i].tag;
					b.pin       = cmd.pin_mask;
					expected_beats.push_back(b);
					fired_cnt++;
				end
				if (fired_cnt == 0)
					expected_beats.push_back(status_beat(STS_OK, 0));
				else
					expected_beats[expected_beats.size() - 1].last = 1'b1;
			end
		endcase
	endtask

	task automatic note_field(input string what, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			mismatch_count++;
			if (lines_printed < PRINT_CAP) begin
				lines_printed++;
				$display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
			end
		end
	endtask

	// Compare the accepted result beat with the oldest one owed
	task automatic check_beat();
		res_t want;
		if (expected_beats.size() == 0) begin
			mismatch_count++;
			if (lines_printed < PRINT_CAP) begin
				lines_printed++;
				$display("%0t: result beat with nothing owed, expected none got status %0d slot %0d fired %0d",
					$time, res.status, res.slot_index, res.fired);
			end
		end else begin
			want = expected_beats.pop_front();
			note_field("status",         32'(want.status),    32'(res.status));
			note_field("slot_index",     32'(want.slot),      32'(res.slot_index));
			note_field("fired",          32'(want.fired),     32'(res.fired));
			note_field("edge_seen",      32'(want.edge_seen), 32'(res.edge_seen));
			note_field("notify_handler", 32'(want.handler),   32'(res.notify_handler));
			note_field("notify_tag",     want.tag,            res.notify_tag);
			note_field("notify_pin",     32'(want.pin),       32'(res.notify_pin));
			note_field("last_result",    32'(want.last),      32'(res.last_result));
		end
	endtask

	// Watch both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_used[i] = 1'b0;
				slot_on[i]   = 1'b0;
				slot_tab[i]  = '0;
			end
			expected_beats.delete();
			mismatch_count = 0;
			lines_printed  = 0;
			beats_owed     <= 0;
		end else begin
			if (cmd.valid && cmd.ready)
				predict_command();
			if (res.valid && res.ready)
				check_beat();
			beats_owed <= expected_beats.size();
		end
	end

endmodule

### test/pin_edge_debounce_dispatch_table_unit_tb.sv
// Testbench top: command stimulus, result back-pressure and the final verdict
`timescale 1ns / 1ps
module pin_edge_debounce_dispatch_table_unit_tb;
	import pdd_pkg::*;

	typedef struct {
		op_t         op;
		logic [2:0]  port;
		logic [15:0] pin;
		logic [15:0] handler;
		logic [31:0] tag;
		logic [1:0]  edges;
		logic [31:0] debounce;
		logic        level;
		logic        enable;
		logic [7:0]  levels;
		logic [31:0] now;
	} pin_cmd_t;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   beats_owed;

	// Idling controls shared with the result side
	bit   sender_no_idle;
	bit   receiver_no_idle;
	int   hold_cycles;

	logic [15:0] pin_pool [4];
	logic [31:0] clock_us;

	pdd_cmd_if cmd ();
	pdd_res_if res ();

	pin_edge_debounce_dispatch_table_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	pdd_dispatch_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.res            (res),
		.mismatch_count (mismatch_count),
		.beats_owed     (beats_owed)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Run limit
	initial begin
		#5000000;
		$display("pin_edge_debounce_dispatch_table_unit: mismatch");
		$finish;
	end

	function automatic pin_cmd_t random_fields();
		pin_cmd_t c;
		c.op       = op_t'($urandom_range(0, 3));
		c.port     = 3'($urandom);
		c.pin      = 16'($urandom);
		c.handler  = 16'($urandom);
		c.tag      = $urandom;
		c.edges    = 2'($urandom);
		c.debounce = $urandom;
		c.level    = 1'($urandom);
		c.enable   = 1'($urandom);
		c.levels   = 8'($urandom);
		c.now      = $urandom;
		return c;
	endfunction

	// Mostly well-formed traffic over a small pin set with a running time base
	function automatic pin_cmd_t next_random_cmd();
		pin_cmd_t c;
		int       pick;
		c    = random_fields();
		pick = $urandom_range(0, 99);
		if (pick < 30)
			c.op = OP_REGISTER;
		else if (pick < 45)
			c.op = OP_UNREGISTER;
		else if (pick < 60)
			c.op = OP_ENABLE;
		else
			c.op = OP_DISPATCH;
		if ($urandom_range(0, 9) != 0)
			c.pin = pin_pool[$urandom_range(0, 3)];
		if ($urandom_range(0, 19) == 0)
			c.handler = '0;
		else if ($urandom_range(0, 9) == 0)
			c.handler = 16'hFFFF;
		c.enable = ($urandom_range(0, 3) != 0);
		pick = $urandom_range(0, 9);
		if (pick < 3)
			c.debounce = '0;
		else if (pick < 8)
			c.debounce = $urandom_range(1, 1500);
		// time mostly creeps forward, sometimes jumps anywhere
		if ($urandom_range(0, 29) == 0)
			clock_us = $urandom;
		else
			clock_us = clock_us + $urandom_range(0, 1200);
		if ($urandom_range(0, 19) != 0)
			c.now = clock_us;
		return c;
	endfunction

	// Offer one command beat and hold it until taken
	task automatic send_cmd(input pin_cmd_t c);
		int gap;
		gap = sender_no_idle ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			cmd.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd.operation     = c.op;
		cmd.port_index    = c.port;
		cmd.pin_mask      = c.pin;
		cmd.handler_id    = c.handler;
		cmd.user_tag      = c.tag;
		cmd.edge_select   = c.edges;
		cmd.debounce_time = c.debounce;
		cmd.current_level = c.level;
		cmd.enable_flag   = c.enable;
		cmd.port_levels   = c.levels;
		cmd.now_time      = c.now;
		cmd.valid         = 1'b1;
		do @(posedge clk); while (!cmd.ready);
		@(negedge clk);
	endtask

	// Result side: random stall per beat, plus an occasional long hold-off
	initial begin
		int stall;
		res.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_cycles != 0) begin
				res.ready = 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			stall = receiver_no_idle ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				res.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res.ready = 1'b1;
			do @(posedge clk); while (!res.valid);
			@(negedge clk);
		end
	end

	// Stimulus and verdict
	initial begin
		pin_cmd_t c;
		cmd.valid         = 1'b0;
		cmd.operation     = OP_REGISTER;
		cmd.port_index    = '0;
		cmd.pin_mask      = '0;
		cmd.handler_id    = '0;
		cmd.user_tag      = '0;
		cmd.edge_select   = EDGE_NONE;
		cmd.debounce_time = '0;
		cmd.current_level = 1'b0;
		cmd.enable_flag   = 1'b0;
		cmd.port_levels   = '0;
		cmd.now_time      = '0;
		sender_no_idle    = 1'b0;
		receiver_no_idle  = 1'b0;
		hold_cycles       = 0;
		clock_us          = 32'hFFFF_FFF0;
		pin_pool[0]       = 16'h0000;
		pin_pool[1]       = 16'hFFFF;
		pin_pool[2]       = 16'($urandom);
		pin_pool[3]       = 16'($urandom);
		arst_n            = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// missing handler, lookups on an empty table, quiet dispatch
		c = random_fields();
		c.op = OP_REGISTER;
		c.handler = '0;
		send_cmd(c);
		c = random_fields();
		c.op = OP_UNREGISTER;
		c.port = 3'd5;
		c.pin = 16'h0000;
		send_cmd(c);
		c.op = OP_ENABLE;
		send_cmd(c);
		c = random_fields();
		c.op = OP_DISPATCH;
		c.pin = 16'h0000;
		send_cmd(c);

		// fill every slot: all ports on two pins, every edge mask
		for (int i = 0; i < SLOTS; i++) begin
			c = random_fields();
			c.op       = OP_REGISTER;
			c.port     = 3'(i % 8);
			c.pin      = (i < 8) ? 16'h0000 : 16'hFFFF;
			c.handler  = (i == SLOTS - 1) ? 16'hFFFF : 16'(i + 1);
			c.tag      = (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'h0 : $urandom;
			c.edges    = 2'(i);
			c.debounce = (i < 4) ? 32'h0 : (i == SLOTS - 1) ? 32'hFFFF_FFFF : 32'd100;
			c.level    = 1'(i % 2);
			c.now      = 32'hFFFF_FFF0;
			send_cmd(c);
		end

		// table full, then reuse of an existing registration
		c = random_fields();
		c.op = OP_REGISTER;
		c.port = 3'd3;
		c.pin = 16'h5555;
		c.handler = 16'd7;
		send_cmd(c);
		c = random_fields();
		c.op = OP_REGISTER;
		c.port = 3'd0;
		c.pin = 16'h0000;
		c.handler = 16'd9;
		c.edges = EDGE_RISE | EDGE_FALL;
		c.debounce = '0;
		c.level = 1'b0;
		c.now = 32'hFFFF_FFF0;
		send_cmd(c);

		// disable one slot, then dispatch across the time wrap and with lockout
		c = random_fields();
		c.op = OP_ENABLE;
		c.port = 3'd1;
		c.pin = 16'h0000;
		c.enable = 1'b0;
		send_cmd(c);
		c = random_fields();
		c.op = OP_DISPATCH;
		c.pin = 16'h0000;
		c.levels = 8'hAA;
		c.now = 32'h0000_0010;
		send_cmd(c);
		c.pin = 16'hFFFF;
		c.levels = 8'h55;
		c.now = 32'h0000_0200;
		send_cmd(c);
		c = random_fields();
		c.op = OP_ENABLE;
		c.port = 3'd1;
		c.pin = 16'h0000;
		c.enable = 1'b1;
		send_cmd(c);
		c.op = OP_UNREGISTER;
		c.port = 3'd0;
		send_cmd(c);
		c = random_fields();
		c.op = OP_DISPATCH;
		c.pin = 16'h0000;
		c.levels = 8'h00;
		c.now = 32'h0000_0300;
		send_cmd(c);

		// random phases with varying idling and pressure
		for (int phase = 0; phase < 6; phase++) begin
			sender_no_idle   = (phase == 1 || phase == 4);
			receiver_no_idle = (phase == 1 || phase == 3);
			if (phase == 2)
				hold_cycles = 400;
			if (phase == 4) begin
				// drain everything before carrying on
				cmd.valid = 1'b0;
				while (beats_owed != 0) @(negedge clk);
			end
			repeat (51) send_cmd(next_random_cmd());
		end
		cmd.valid = 1'b0;

		// let the block drain, then allow for stray beats
		while (beats_owed != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (mismatch_count == 0)
			$display("pin_edge_debounce_dispatch_table_unit: match");
		else
			$display("pin_edge_debounce_dispatch_table_unit: mismatch");
		$finish;
	end

endmodule
